// ----- src/obd_ascii_response_parser_assert.svh -----
// Assertion macros shared by the response parser RTL.
// Both macros sample on clk and are disabled while rst is high.
`ifndef OBD_ASCII_RESPONSE_PARSER_ASSERT_SVH
`define OBD_ASCII_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define OBDP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define OBDP_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/obdp_pkg.sv -----
// ----------------------------------------------------------------------------
// OBD response parser package
// Constants, codes and small decode functions of the response line parser.
// ----------------------------------------------------------------------------
package obdp_pkg;

  localparam int MaxBytes = 16;
  localparam int CountW   = $clog2(MaxBytes + 1);
  localparam int CountXW  = CountW + 1;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusRejected  = 2'd1;
  localparam logic [1:0] StatusMalformed = 2'd2;

  // Requested metric codes.
  localparam logic [2:0] MetricCoolant = 3'd0;
  localparam logic [2:0] MetricIntake  = 3'd1;
  localparam logic [2:0] MetricFuel    = 3'd2;
  localparam logic [2:0] MetricVoltage = 3'd3;
  localparam logic [2:0] MetricOil     = 3'd4;
  localparam logic [2:0] MetricBoost   = 3'd5;

  localparam logic [7:0] EchoByte  = 8'h41;
  localparam logic [7:0] CharQuery = 8'h3F;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNull  = 8'h00;

  // Reciprocal of 255 folded with the factor 1000; exact for every 8-bit input.
  localparam logic [23:0] FuelMul   = 24'd8224200;
  localparam int          FuelShift = 21;

  function automatic logic [7:0] pid_of(input logic [2:0] metric);
    logic [7:0] pid;
    unique case (metric)
      MetricCoolant: pid = 8'h05;
      MetricIntake:  pid = 8'h0F;
      MetricFuel:    pid = 8'h2F;
      MetricVoltage: pid = 8'h42;
      MetricOil:     pid = 8'h5C;
      MetricBoost:   pid = 8'h70;
      default:       pid = 8'h00;
    endcase
    return pid;
  endfunction

  function automatic logic [2:0] len_of(input logic [2:0] metric);
    logic [2:0] n;
    unique case (metric)
      MetricVoltage: n = 3'd2;
      MetricBoost:   n = 3'd4;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    return (k == 2'd3) ? 3'd5 : 3'd7;
  endfunction

  // Character p (counted from the first) of keyword k.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [55:0] text;
    logic [5:0]  idx;
    unique case (k)
      2'd0:    text = "NO DATA";
      2'd1:    text = "no data";
      2'd2:    text = "STOPPED";
      default: text = {16'h0000, "ERROR"};
    endcase
    idx = {3'(kw_len(k) - 3'd1 - p), 3'b000};
    return text[idx +: 8];
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    if (c >= "0" && c <= "9") begin
      n = {1'b0, 4'(c - 8'h30)};
    end else if (c >= "A" && c <= "F") begin
      n = {1'b0, 4'(c - 8'h37)};
    end else if (c >= "a" && c <= "f") begin
      n = {1'b0, 4'(c - 8'h57)};
    end else begin
      n = 5'h10;
    end
    return n;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ----- src/obdp_in_if.sv -----
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one response character per beat.
// ----------------------------------------------------------------------------
interface obdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;
  logic [2:0] requested_metric;

  modport source (output valid, char_code, line_end, requested_metric, input ready);
  modport sink   (input valid, char_code, line_end, requested_metric, output ready);
endinterface

// ----- src/obdp_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parsed line result per beat.
// ----------------------------------------------------------------------------
interface obdp_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [16:0] eng_value;

  modport source (output valid, status, eng_value, input ready);
  modport sink   (input valid, status, eng_value, output ready);
endinterface

// ----- src/obd_ascii_response_parser.sv -----
// ----------------------------------------------------------------------------
// OBD ASCII response parser
// Parses mode 01 response lines character by character into scaled values.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one ASCII character per beat with a line_end mark on the
//   last character of a line; requested_metric is sampled on the first beat
//   of each line. results carries one beat per line: status and the scaled
//   value (zero unless status is ok).
//   A character beat is taken into an input register, then the line state
//   and, on a line_end beat, the result register are updated from it. A
//   result beat is offered from the result register after that update.
//   Throughput is one character per cycle while chars.ready is high; the
//   line state is updated by a single pass of logic per character.
//   When results stalls, characters keep flowing until a line_end beat
//   reaches the input register while the result register is still full;
//   chars.ready then drops until the result beat is taken.
//   Reset clears both registers' valid flags and all line state, so the
//   next beat starts a new line.
// ----------------------------------------------------------------------------
module obd_ascii_response_parser
  import obdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  obdp_in_if.sink     chars,
  obdp_out_if.source  results
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_line_end;
  logic [2:0] s1_metric;
  logic       s1_advance;

  // Line state.
  logic              at_line_start, at_line_start_next;
  logic [2:0]        latched_metric, latched_metric_next;
  logic [3:0][2:0]   kw_prog, kw_prog_next;
  logic              reject_seen, reject_seen_next;
  logic              content_ended, content_ended_next;
  logic              hex_stopped, hex_stopped_next;
  logic              hi_pending, hi_pending_next;
  logic [3:0]        hi_nibble, hi_nibble_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        prev_byte, prev_byte_next;
  logic              echo_found, echo_found_next;
  logic [CountW-1:0] data_start, data_start_next;
  logic [7:0]        cap_a, cap_a_next;
  logic [7:0]        cap_b, cap_b_next;
  logic [7:0]        cap_d, cap_d_next;

  // Result register.
  logic               res_valid;
  logic [1:0]         res_status, res_status_next;
  logic signed [16:0] res_value, res_value_next;

  assign s1_advance  = s1_valid && (!s1_line_end || !res_valid || results.ready);
  assign chars.ready = !s1_valid || s1_advance;

  assign results.valid     = res_valid;
  assign results.status    = res_status;
  assign results.eng_value = res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char     <= chars.char_code;
      s1_line_end <= chars.line_end;
      s1_metric   <= chars.requested_metric;
    end
  end

  always_comb begin
    logic              first;
    logic [4:0]        nib;
    logic [7:0]        b;
    logic [2:0]        p;
    logic [2:0]        kl;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] off;
    logic [2:0]        need;
    logic [CountXW-1:0] min_total;
    logic [CountXW-1:0] min_after;
    logic signed [16:0] base;
    logic [31:0]        fuel_prod;

    first = at_line_start;
    latched_metric_next = at_line_start ? s1_metric : latched_metric;
    if (at_line_start) begin
      kw_prog_next       = '0;
      reject_seen_next   = 1'b0;
      content_ended_next = 1'b0;
      hex_stopped_next   = 1'b0;
      hi_pending_next    = 1'b0;
      hi_nibble_next     = '0;
      byte_count_next    = '0;
      prev_byte_next     = '0;
      echo_found_next    = 1'b0;
      data_start_next    = '0;
      cap_a_next         = '0;
      cap_b_next         = '0;
      cap_d_next         = '0;
    end else begin
      kw_prog_next       = kw_prog;
      reject_seen_next   = reject_seen;
      content_ended_next = content_ended;
      hex_stopped_next   = hex_stopped;
      hi_pending_next    = hi_pending;
      hi_nibble_next     = hi_nibble;
      byte_count_next    = byte_count;
      prev_byte_next     = prev_byte;
      echo_found_next    = echo_found;
      data_start_next    = data_start;
      cap_a_next         = cap_a;
      cap_b_next         = cap_b;
      cap_d_next         = cap_d;
    end
    at_line_start_next = s1_line_end;

    nib = nibble_of(s1_char);
    b   = {hi_nibble_next, nib[3:0]};
    pos = byte_count_next;
    off = pos - data_start_next;

    if (!content_ended_next) begin
      if (s1_char == CharNull) begin
        content_ended_next = 1'b1;
      end else begin
        if (first && s1_char == CharQuery) begin
          reject_seen_next = 1'b1;
        end

        // Each keyword is tracked by its own match position.
        for (int k = 0; k < 4; k++) begin
          p  = kw_prog_next[k];
          kl = kw_len(2'(k));
          if (p < kl && s1_char == kw_char(2'(k), p)) begin
            p = p + 3'd1;
          end else begin
            p = (s1_char == kw_char(2'(k), 3'd0)) ? 3'd1 : 3'd0;
          end
          if (p >= kl) begin
            reject_seen_next = 1'b1;
            p = 3'd0;
          end
          kw_prog_next[k] = p;
        end

        if (!hex_stopped_next && byte_count_next < CountW'(MaxBytes)) begin
          if (!hi_pending_next) begin
            if (!is_space(s1_char)) begin
              if (nib[4]) begin
                hex_stopped_next = 1'b1;
              end else begin
                hi_nibble_next  = nib[3:0];
                hi_pending_next = 1'b1;
              end
            end
          end else if (nib[4]) begin
            hex_stopped_next = 1'b1;
          end else begin
            hi_pending_next = 1'b0;
            if (!echo_found_next) begin
              if (pos != '0 && prev_byte_next == EchoByte &&
                  b == pid_of(latched_metric_next)) begin
                echo_found_next = 1'b1;
                data_start_next = pos + CountW'(1);
              end
            end else begin
              case (off)
                CountW'(0): cap_a_next = b;
                CountW'(1): cap_b_next = b;
                CountW'(3): cap_d_next = b;
                default: ;
              endcase
            end
            prev_byte_next  = b;
            byte_count_next = pos + CountW'(1);
          end
        end
      end
    end

    // Line result, taken from the state after this character.
    need      = len_of(latched_metric_next);
    min_total = CountXW'(need) + CountXW'(2);
    min_after = {1'b0, data_start_next} + CountXW'(need);
    fuel_prod = 32'(cap_a_next) * 32'(FuelMul);
    base      = '0;
    res_value_next = '0;
    if (latched_metric_next > MetricBoost) begin
      res_status_next = StatusMalformed;
    end else if (reject_seen_next) begin
      res_status_next = StatusRejected;
    end else if ({1'b0, byte_count_next} < min_total || !echo_found_next ||
                 {1'b0, byte_count_next} < min_after) begin
      res_status_next = StatusMalformed;
    end else begin
      res_status_next = StatusOk;
      case (latched_metric_next)
        MetricFuel: begin
          res_value_next = {7'b0, fuel_prod[FuelShift +: 10]};
        end
        MetricVoltage: begin
          res_value_next = {1'b0, cap_a_next, cap_b_next};
        end
        MetricBoost: begin
          base = $signed({9'b0, cap_d_next}) - 17'sd128;
          res_value_next = base * 17'sd10;
        end
        default: begin
          base = $signed({9'b0, cap_a_next}) - 17'sd40;
          res_value_next = base * 17'sd10;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start  <= 1'b1;
      latched_metric <= '0;
      kw_prog        <= '0;
      reject_seen    <= 1'b0;
      content_ended  <= 1'b0;
      hex_stopped    <= 1'b0;
      hi_pending     <= 1'b0;
      hi_nibble      <= '0;
      byte_count     <= '0;
      prev_byte      <= '0;
      echo_found     <= 1'b0;
      data_start     <= '0;
      cap_a          <= '0;
      cap_b          <= '0;
      cap_d          <= '0;
    end else if (s1_advance) begin
      at_line_start  <= at_line_start_next;
      latched_metric <= latched_metric_next;
      kw_prog        <= kw_prog_next;
      reject_seen    <= reject_seen_next;
      content_ended  <= content_ended_next;
      hex_stopped    <= hex_stopped_next;
      hi_pending     <= hi_pending_next;
      hi_nibble      <= hi_nibble_next;
      byte_count     <= byte_count_next;
      prev_byte      <= prev_byte_next;
      echo_found     <= echo_found_next;
      data_start     <= data_start_next;
      cap_a          <= cap_a_next;
      cap_b          <= cap_b_next;
      cap_d          <= cap_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance && s1_line_end) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_line_end) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end
  end

`include "obd_ascii_response_parser_assert.svh"

  `OBDP_ASSERT_IMP(a_value_zero_unless_ok, res_valid && res_status != StatusOk,
    res_value == '0, "scaled value not zero on a failed line")
  `OBDP_ASSERT_IMP(a_count_bound, 1'b1, byte_count <= CountW'(MaxBytes),
    "byte count beyond the line limit")
  `OBDP_ASSERT_IMP(a_echo_position, echo_found && !at_line_start,
    data_start >= CountW'(2) && data_start <= byte_count,
    "data start outside the bytes read")
  `OBDP_ASSERT_NXT(a_line_end_gives_result, s1_advance && s1_line_end,
    res_valid, "line end beat did not load a result")
  `OBDP_ASSERT_IMP(a_result_from_line_end, $rose(res_valid),
    $past(s1_valid && s1_line_end), "result appeared without a line end beat")

endmodule
